[rtl/vuh_pkg.sv]
package vuh_pkg;

    localparam int MAX_LEADING_ZEROS_DEF = 20;
    localparam int MAX_CPB_ENTRIES_DEF   = 32;
    localparam int MAX_SUB_LAYERS_DEF    = 7;
    localparam int QUEUE_DEPTH           = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WARN    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [5:0] ID_ASPECT_FLAG    = 6'd0;
    localparam logic [5:0] ID_SAR_W          = 6'd1;
    localparam logic [5:0] ID_OVERSCAN_FLAG  = 6'd3;
    localparam logic [5:0] ID_SIGNAL_FLAG    = 6'd5;
    localparam logic [5:0] ID_VIDEO_FORMAT   = 6'd6;
    localparam logic [5:0] ID_COLOUR_FLAG    = 6'd8;
    localparam logic [5:0] ID_PRIMARIES      = 6'd9;
    localparam logic [5:0] ID_TRANSFER       = 6'd10;
    localparam logic [5:0] ID_MATRIX         = 6'd11;
    localparam logic [5:0] ID_CHROMA_FLAG    = 6'd12;
    localparam logic [5:0] ID_WINDOW_FLAG    = 6'd18;
    localparam logic [5:0] ID_TIMING_FLAG    = 6'd23;
    localparam logic [5:0] ID_POC_FLAG       = 6'd26;
    localparam logic [5:0] ID_TICKS_POC      = 6'd27;
    localparam logic [5:0] ID_HRD_FLAG       = 6'd28;
    localparam logic [5:0] ID_NAL_FLAG       = 6'd29;
    localparam logic [5:0] ID_VCL_FLAG       = 6'd30;
    localparam logic [5:0] ID_SUBPIC_FLAG    = 6'd31;
    localparam logic [5:0] ID_TICK_DIV       = 6'd32;
    localparam logic [5:0] ID_DU_INC_LEN     = 6'd33;
    localparam logic [5:0] ID_DPB_DU_LEN     = 6'd35;
    localparam logic [5:0] ID_CPB_SIZE_SCALE = 6'd37;
    localparam logic [5:0] ID_CPB_DU_SCALE   = 6'd38;
    localparam logic [5:0] ID_INIT_DELAY_LEN = 6'd39;
    localparam logic [5:0] ID_AU_DELAY_LEN   = 6'd40;
    localparam logic [5:0] ID_DPB_DELAY_LEN  = 6'd41;
    localparam logic [5:0] ID_FIXED_GEN      = 6'd42;
    localparam logic [5:0] ID_FIXED_CVS      = 6'd43;
    localparam logic [5:0] ID_ELEM_DUR       = 6'd44;
    localparam logic [5:0] ID_LOW_DELAY      = 6'd45;
    localparam logic [5:0] ID_CPB_CNT        = 6'd46;
    localparam logic [5:0] ID_BIT_RATE       = 6'd47;
    localparam logic [5:0] ID_CPB_SIZE       = 6'd48;
    localparam logic [5:0] ID_CPB_SIZE_DU    = 6'd49;
    localparam logic [5:0] ID_BIT_RATE_DU    = 6'd50;
    localparam logic [5:0] ID_CBR            = 6'd51;
    localparam logic [5:0] ID_RESTRICT_FLAG  = 6'd52;
    localparam logic [5:0] ID_MV_OVER_BOUND  = 6'd54;
    localparam logic [5:0] ID_MIN_SEG        = 6'd56;
    localparam logic [5:0] ID_BYTES_DENOM    = 6'd57;
    localparam logic [5:0] ID_BITS_DENOM     = 6'd58;
    localparam logic [5:0] ID_MV_H           = 6'd59;
    localparam logic [5:0] ID_MV_V           = 6'd60;
    localparam logic [5:0] POS_ASPECT_IDC    = 6'd61;
    localparam logic [5:0] POS_LAST          = 6'd61;

    // 0 marks an exp-Golomb code; two pad entries for unused positions
    localparam logic [5:0] READ_WIDTH [64] = '{
        6'd1, 6'd16, 6'd16, 6'd1, 6'd1, 6'd1, 6'd3, 6'd1, 6'd1, 6'd8,
        6'd8, 6'd8, 6'd1, 6'd0, 6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd0,
        6'd0, 6'd0, 6'd0, 6'd1, 6'd32, 6'd32, 6'd1, 6'd0, 6'd1, 6'd1,
        6'd1, 6'd1, 6'd8, 6'd5, 6'd1, 6'd5, 6'd4, 6'd4, 6'd4, 6'd5,
        6'd5, 6'd5, 6'd1, 6'd1, 6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0,
        6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0,
        6'd0, 6'd8, 6'd0, 6'd0
    };

    localparam logic [7:0] ASPECT_W [17] = '{
        8'd0, 8'd1, 8'd12, 8'd10, 8'd16, 8'd40, 8'd24, 8'd20, 8'd32,
        8'd80, 8'd18, 8'd15, 8'd64, 8'd160, 8'd4, 8'd3, 8'd2
    };
    localparam logic [7:0] ASPECT_H [17] = '{
        8'd0, 8'd1, 8'd11, 8'd11, 8'd11, 8'd33, 8'd11, 8'd11, 8'd11,
        8'd33, 8'd11, 8'd11, 8'd33, 8'd99, 8'd3, 8'd2, 8'd1
    };

    typedef struct packed {
        logic bit_value;
        logic header_start;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  element_id;
        logic [31:0] element_value;
        logic [2:0]  sub_layer;
        logic [4:0]  cpb_index;
        logic        hrd_kind;
        logic [1:0]  status;
        logic        last_of_run;
        logic        header_done;
    } out_item_t;

    // one decoded element, expanded into its results by the back end
    typedef struct packed {
        logic [5:0]  pos;
        logic [31:0] value;
        logic        err;
        logic [2:0]  layer;
        logic [4:0]  entry;
        logic        vclpass;
        logic        done;
    } event_t;

    function automatic logic [31:0] default_value(input logic [5:0] id);
        logic [31:0] r;
        r = 32'd0;
        case (id)
            ID_VIDEO_FORMAT:                        r = 32'd5;
            ID_PRIMARIES, ID_TRANSFER, ID_MATRIX:   r = 32'd2;
            ID_TICKS_POC, ID_FIXED_CVS, ID_CPB_CNT: r = 32'd1;
            ID_MV_OVER_BOUND, ID_BITS_DENOM:        r = 32'd1;
            ID_BYTES_DENOM:                         r = 32'd2;
            ID_MV_H, ID_MV_V:                       r = 32'd15;
            default:                                r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/vuh_front.sv]
module vuh_front #(
    parameter int MAX_LEADING_ZEROS = vuh_pkg::MAX_LEADING_ZEROS_DEF,
    parameter int MAX_CPB_ENTRIES   = vuh_pkg::MAX_CPB_ENTRIES_DEF,
    parameter int MAX_SUB_LAYERS    = vuh_pkg::MAX_SUB_LAYERS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  vuh_pkg::in_item_t item,
    input  logic [2:0]       max_sub_layers,
    output logic             ev_valid,
    output vuh_pkg::event_t  ev
);
    import vuh_pkg::*;

    localparam logic [4:0] LZ_MAX  = 5'(MAX_LEADING_ZEROS);
    localparam logic [5:0] CPB_MAX = 6'(MAX_CPB_ENTRIES);
    localparam logic [2:0] SL_MAX  = 3'(MAX_SUB_LAYERS);
    localparam int FL_NAL = 0;
    localparam int FL_VCL = 1;
    localparam int FL_SUBPIC = 2;
    localparam int FL_VCLPASS = 3;

    logic        idle_reg, idle_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  lz_reg, lz_next;
    logic        sfx_reg, sfx_next;
    logic [2:0]  layer_reg, layer_next;
    logic [5:0]  entry_reg, entry_next;
    logic [5:0]  total_reg, total_next;
    logic [3:0]  flags_reg, flags_next;

    logic        e_idle;
    logic [5:0]  e_pos, e_cnt, e_entry, e_total;
    logic [31:0] e_acc;
    logic [4:0]  e_lz;
    logic        e_sfx;
    logic [2:0]  e_layer;
    logic [3:0]  e_flags;

    logic [5:0]  width;
    logic [31:0] acc_sh, cv;
    logic [5:0]  cnt_inc, entry_inc;
    logic        do_cmp, do_err;
    logic [2:0]  lim, layer_inc;
    logic [5:0]  nl_pos;
    logic [3:0]  fl30;

    always_comb
    begin
        if (item.header_start)
        begin
            e_idle = 1'b0; e_pos = 6'd0; e_cnt = 6'd0; e_acc = 32'd0;
            e_lz = 5'd0; e_sfx = 1'b0; e_layer = 3'd0; e_entry = 6'd0;
            e_total = 6'd1; e_flags = 4'd0;
        end
        else
        begin
            e_idle = idle_reg; e_pos = pos_reg; e_cnt = cnt_reg; e_acc = acc_reg;
            e_lz = lz_reg; e_sfx = sfx_reg; e_layer = layer_reg; e_entry = entry_reg;
            e_total = total_reg; e_flags = flags_reg;
        end
    end

    always_comb
    begin
        if (max_sub_layers == 3'd0)
            lim = 3'd1;
        else if (max_sub_layers > SL_MAX)
            lim = SL_MAX;
        else
            lim = max_sub_layers;
        layer_inc = e_layer + 3'd1;
        nl_pos    = (layer_inc < lim) ? ID_FIXED_GEN : ID_RESTRICT_FLAG;
        width     = READ_WIDTH[e_pos];
        acc_sh    = {e_acc[30:0], item.bit_value};
        cnt_inc   = e_cnt + 6'd1;
        entry_inc = e_entry + 6'd1;
        fl30      = e_flags;

        idle_next = e_idle; pos_next = e_pos; cnt_next = e_cnt; acc_next = e_acc;
        lz_next = e_lz; sfx_next = e_sfx; layer_next = e_layer; entry_next = e_entry;
        total_next = e_total; flags_next = e_flags;

        do_cmp = 1'b0;
        do_err = 1'b0;
        cv     = 32'd0;

        ev_valid   = 1'b0;
        ev.pos     = e_pos;
        ev.value   = 32'd0;
        ev.err     = 1'b0;
        ev.layer   = e_layer;
        ev.entry   = e_entry[4:0];
        ev.vclpass = e_flags[FL_VCLPASS];
        ev.done    = 1'b0;

        if (!e_idle && e_pos > POS_LAST)
            idle_next = 1'b1;
        else if (!e_idle)
        begin
            if (width != 6'd0)
            begin
                acc_next = acc_sh;
                cnt_next = cnt_inc;
                if (cnt_inc >= width)
                begin
                    do_cmp = 1'b1;
                    cv     = acc_sh;
                end
            end
            else if (!e_sfx)
            begin
                if (item.bit_value)
                begin
                    if (e_lz == 5'd0)
                        do_cmp = 1'b1;
                    else
                    begin
                        sfx_next = 1'b1;
                        cnt_next = 6'd0;
                        acc_next = 32'd0;
                    end
                end
                else if (e_lz >= LZ_MAX)
                    do_err = 1'b1;
                else
                    lz_next = e_lz + 5'd1;
            end
            else
            begin
                acc_next = acc_sh;
                cnt_next = cnt_inc;
                if (cnt_inc >= {1'b0, e_lz})
                begin
                    do_cmp = 1'b1;
                    cv     = ((32'd1 << e_lz) - 32'd1) + acc_sh;
                end
            end

            if (do_err || do_cmp)
            begin
                cnt_next = 6'd0;
                acc_next = 32'd0;
                lz_next  = 5'd0;
                sfx_next = 1'b0;
                ev_valid = 1'b1;
            end

            if (do_err)
            begin
                ev.err = 1'b1;
                if (e_pos >= ID_FIXED_GEN && e_pos <= ID_BIT_RATE_DU)
                    pos_next = ID_RESTRICT_FLAG;
                else
                begin
                    idle_next = 1'b1;
                    ev.done   = 1'b1;
                end
            end

            if (do_cmp)
            begin
                ev.value = cv;
                pos_next = e_pos + 6'd1;
                case (e_pos)
                    ID_ASPECT_FLAG:
                        pos_next = (cv != 32'd0) ? POS_ASPECT_IDC : ID_OVERSCAN_FLAG;
                    POS_ASPECT_IDC:
                    begin
                        if (cv == 32'd255)
                        begin
                            ev_valid = 1'b0;
                            pos_next = ID_SAR_W;
                        end
                        else
                            pos_next = ID_OVERSCAN_FLAG;
                    end
                    ID_OVERSCAN_FLAG:
                        pos_next = (cv != 32'd0) ? e_pos + 6'd1 : ID_SIGNAL_FLAG;
                    ID_SIGNAL_FLAG:
                        pos_next = (cv != 32'd0) ? ID_VIDEO_FORMAT : ID_CHROMA_FLAG;
                    ID_COLOUR_FLAG:
                        pos_next = (cv != 32'd0) ? ID_PRIMARIES : ID_CHROMA_FLAG;
                    ID_CHROMA_FLAG:
                        pos_next = (cv != 32'd0) ? e_pos + 6'd1 : e_pos + 6'd3;
                    ID_WINDOW_FLAG:
                        pos_next = (cv != 32'd0) ? e_pos + 6'd1 : ID_TIMING_FLAG;
                    ID_TIMING_FLAG:
                        pos_next = (cv != 32'd0) ? e_pos + 6'd1 : ID_RESTRICT_FLAG;
                    ID_POC_FLAG:
                        pos_next = (cv != 32'd0) ? ID_TICKS_POC : ID_HRD_FLAG;
                    ID_HRD_FLAG:
                        pos_next = (cv != 32'd0) ? ID_NAL_FLAG : ID_RESTRICT_FLAG;
                    ID_NAL_FLAG:
                        flags_next[FL_NAL] = e_flags[FL_NAL] | (cv != 32'd0);
                    ID_VCL_FLAG:
                    begin
                        fl30[FL_VCL] = e_flags[FL_VCL] | (cv != 32'd0);
                        flags_next   = fl30;
                        layer_next   = 3'd0;
                        pos_next     = (fl30[FL_NAL] || fl30[FL_VCL]) ?
                                       ID_SUBPIC_FLAG : ID_FIXED_GEN;
                    end
                    ID_SUBPIC_FLAG:
                    begin
                        if (cv != 32'd0)
                        begin
                            flags_next[FL_SUBPIC] = 1'b1;
                            pos_next = ID_TICK_DIV;
                        end
                        else
                            pos_next = ID_TICK_DIV + 6'd4;
                    end
                    ID_CPB_SIZE_SCALE:
                        pos_next = e_flags[FL_SUBPIC] ? ID_CPB_DU_SCALE : ID_INIT_DELAY_LEN;
                    ID_DPB_DELAY_LEN:
                    begin
                        layer_next = 3'd0;
                        pos_next   = ID_FIXED_GEN;
                    end
                    ID_FIXED_GEN:
                        pos_next = (cv != 32'd0) ? ID_ELEM_DUR : ID_FIXED_CVS;
                    ID_FIXED_CVS:
                        pos_next = (cv != 32'd0) ? ID_ELEM_DUR : ID_LOW_DELAY;
                    ID_ELEM_DUR:
                        pos_next = ID_CPB_CNT;
                    ID_LOW_DELAY, ID_CPB_CNT:
                    begin
                        if (e_pos == ID_LOW_DELAY && cv == 32'd0)
                            pos_next = ID_CPB_CNT;
                        else
                        begin
                            if (e_pos == ID_LOW_DELAY)
                                total_next = 6'd1;
                            else if (cv >= 32'(MAX_CPB_ENTRIES))
                                total_next = CPB_MAX;
                            else
                                total_next = cv[5:0] + 6'd1;
                            if (e_flags[FL_NAL] || e_flags[FL_VCL])
                            begin
                                flags_next[FL_VCLPASS] = !e_flags[FL_NAL];
                                entry_next = 6'd0;
                                pos_next   = ID_BIT_RATE;
                            end
                            else
                            begin
                                layer_next = layer_inc;
                                pos_next   = nl_pos;
                            end
                        end
                    end
                    ID_CPB_SIZE:
                        pos_next = e_flags[FL_SUBPIC] ? ID_CPB_SIZE_DU : ID_CBR;
                    ID_CBR:
                    begin
                        entry_next = entry_inc;
                        if (entry_inc < e_total)
                            pos_next = ID_BIT_RATE;
                        else if (!e_flags[FL_VCLPASS] && e_flags[FL_VCL])
                        begin
                            flags_next[FL_VCLPASS] = 1'b1;
                            entry_next = 6'd0;
                            pos_next   = ID_BIT_RATE;
                        end
                        else
                        begin
                            layer_next = layer_inc;
                            pos_next   = nl_pos;
                        end
                    end
                    ID_RESTRICT_FLAG:
                    begin
                        if (cv == 32'd0)
                        begin
                            idle_next = 1'b1;
                            ev.done   = 1'b1;
                        end
                    end
                    ID_MV_V:
                    begin
                        idle_next = 1'b1;
                        ev.done   = 1'b1;
                    end
                    default:
                        pos_next = e_pos + 6'd1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= 1'b1;
            pos_reg   <= 6'd0;
            cnt_reg   <= 6'd0;
            acc_reg   <= 32'd0;
            lz_reg    <= 5'd0;
            sfx_reg   <= 1'b0;
            layer_reg <= 3'd0;
            entry_reg <= 6'd0;
            total_reg <= 6'd1;
            flags_reg <= 4'd0;
        end
        else if (take)
        begin
            idle_reg  <= idle_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            lz_reg    <= lz_next;
            sfx_reg   <= sfx_next;
            layer_reg <= layer_next;
            entry_reg <= entry_next;
            total_reg <= total_next;
            flags_reg <= flags_next;
        end
    end

endmodule

[rtl/vuh_fifo.sv]
module vuh_fifo #(
    parameter int DEPTH = vuh_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vuh_pkg::event_t din,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output vuh_pkg::event_t dout
);
    import vuh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    event_t          mem [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign dout      = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

[rtl/vuh_back.sv]
module vuh_back #(
    parameter int MAX_CPB_ENTRIES = vuh_pkg::MAX_CPB_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    input  vuh_pkg::event_t    ev,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output vuh_pkg::out_item_t out_data
);
    import vuh_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic [3:0]  n;
    logic        vz, load, last;
    logic [5:0]  id;
    logic [31:0] v, val;
    logic [1:0]  st;
    logic        per_layer, per_cpb;

    always_comb
    begin
        v  = ev.value;
        vz = (v == 32'd0);
        case (ev.pos)
            ID_ASPECT_FLAG:   n = vz ? 4'd3 : 4'd1;
            POS_ASPECT_IDC:   n = 4'd2;
            ID_OVERSCAN_FLAG: n = vz ? 4'd2 : 4'd1;
            ID_SIGNAL_FLAG:   n = vz ? 4'd7 : 4'd1;
            ID_COLOUR_FLAG:   n = vz ? 4'd4 : 4'd1;
            ID_CHROMA_FLAG:   n = vz ? 4'd3 : 4'd1;
            ID_WINDOW_FLAG:   n = vz ? 4'd5 : 4'd1;
            ID_TIMING_FLAG:   n = vz ? 4'd6 : 4'd1;
            ID_POC_FLAG:      n = vz ? 4'd2 : 4'd1;
            ID_FIXED_GEN:     n = vz ? 4'd1 : 4'd2;
            ID_ELEM_DUR:      n = 4'd2;
            ID_LOW_DELAY:     n = vz ? 4'd1 : 4'd2;
            ID_RESTRICT_FLAG: n = vz ? 4'd9 : 4'd1;
            default:          n = 4'd1;
        endcase
        if (ev.err)
            n = 4'd1;

        id = (ev.pos == POS_ASPECT_IDC) ? 6'(ID_SAR_W + 6'(idx_reg))
                                        : 6'(ev.pos + 6'(idx_reg));
        st  = ST_OK;
        val = v;
        if (ev.err)
        begin
            val = 32'd0;
            st  = ST_INVALID;
        end
        else if (ev.pos == POS_ASPECT_IDC)
        begin
            if (v <= 32'd16)
                val = 32'(idx_reg == 4'd0 ? ASPECT_W[v[4:0]] : ASPECT_H[v[4:0]]);
            else
                val = 32'd0;
        end
        else if (idx_reg != 4'd0)
            val = default_value(id);
        else
        begin
            case (ev.pos)
                ID_VIDEO_FORMAT: val = (v > 32'd5) ? 32'd5 : v;
                ID_PRIMARIES:
                    val = (vz || v == 32'd3 || v >= 32'd11) ? 32'd2 : v;
                ID_TRANSFER:
                    val = (vz || v == 32'd3 || v >= 32'd18) ? 32'd2 : v;
                ID_MATRIX:   val = (vz || v >= 32'd11) ? 32'd2 : v;
                ID_TICK_DIV: val = v + 32'd2;
                ID_TICKS_POC, ID_DU_INC_LEN, ID_DPB_DU_LEN, ID_INIT_DELAY_LEN,
                ID_AU_DELAY_LEN, ID_DPB_DELAY_LEN, ID_ELEM_DUR, ID_BIT_RATE,
                ID_CPB_SIZE, ID_CPB_SIZE_DU, ID_BIT_RATE_DU:
                    val = v + 32'd1;
                ID_CPB_CNT:
                begin
                    if (v >= 32'(MAX_CPB_ENTRIES))
                    begin
                        val = 32'(MAX_CPB_ENTRIES);
                        st  = ST_WARN;
                    end
                    else
                        val = v + 32'd1;
                end
                ID_MIN_SEG:
                    if (v > 32'd4095) begin val = 32'd0; st = ST_WARN; end
                ID_BYTES_DENOM:
                    if (v > 32'd16) begin val = 32'd2; st = ST_WARN; end
                ID_BITS_DENOM:
                    if (v > 32'd16) begin val = 32'd1; st = ST_WARN; end
                ID_MV_H, ID_MV_V:
                    if (v > 32'd15) begin val = 32'd15; st = ST_WARN; end
                default: val = v;
            endcase
        end

        per_layer = (id >= ID_FIXED_GEN) && (id <= ID_CBR);
        per_cpb   = (id >= ID_BIT_RATE) && (id <= ID_CBR);
        last      = (idx_reg == n - 4'd1);
        load      = ev_valid && (!out_valid_reg || !out_stall);
        pop       = load && last;

        out_next               = out_reg;
        out_next.element_id    = id;
        out_next.element_value = val;
        out_next.sub_layer     = per_layer ? ev.layer : 3'd0;
        out_next.cpb_index     = per_cpb ? ev.entry : 5'd0;
        out_next.hrd_kind      = per_cpb ? ev.vclpass : 1'b0;
        out_next.status        = st;
        out_next.last_of_run   = last;
        out_next.header_done   = last && ev.done;

        idx_next       = load ? (last ? 4'd0 : idx_reg + 4'd1) : idx_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.header_done |-> out_data.last_of_run)
        else $error("header end not on last result of a run");

    a_scalar_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.element_id < ID_FIXED_GEN
        |-> out_data.sub_layer == 3'd0 && out_data.cpb_index == 5'd0)
        else $error("loop index on a non-loop element");

    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.element_id <= ID_MV_V && out_data.status <= ST_INVALID)
        else $error("element id or status out of range");

endmodule

[rtl/video_usability_header_parser.sv]
// Path: a bit's first result passes through the event queue and then the output register.
// Throughput: one bit per cycle while the event queue is not full; a bit whose element
//   fans out into k results yields them one by one, and a 4-entry event queue absorbs the bursts.
// Up to 9 results per bit (restriction defaults), one result per cycle while out_stall is low.
// Reset: parser idle until a header start, sub-layer count 1, queue and output empty.
module video_usability_header_parser #(
    parameter int MAX_LEADING_ZEROS = vuh_pkg::MAX_LEADING_ZEROS_DEF,
    parameter int MAX_CPB_ENTRIES   = vuh_pkg::MAX_CPB_ENTRIES_DEF,
    parameter int MAX_SUB_LAYERS    = vuh_pkg::MAX_SUB_LAYERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  vuh_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output vuh_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data
);
    import vuh_pkg::*;

    logic       cfg_we;
    logic [2:0] max_sub_layers_reg;
    logic       take, ev_valid, q_full, q_valid, q_pop;
    event_t     ev, q_ev;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign take      = in_valid && !q_full;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_sub_layers_reg <= 3'd1;
        else if (cfg_we)
            max_sub_layers_reg <= cfg_data;
    end

    vuh_front #(
        .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS),
        .MAX_CPB_ENTRIES   (MAX_CPB_ENTRIES),
        .MAX_SUB_LAYERS    (MAX_SUB_LAYERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .item           (in_data),
        .max_sub_layers (max_sub_layers_reg),
        .ev_valid       (ev_valid),
        .ev             (ev)
    );

    vuh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && ev_valid),
        .din       (ev),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (q_ev)
    );

    vuh_back #(
        .MAX_CPB_ENTRIES (MAX_CPB_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (q_valid),
        .ev        (q_ev),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
